>>> rtl/ocep_pkg.sv
// Shared types, control word layout and arithmetic helpers for the orbit camera eye block.
`timescale 1ns / 1ps

package ocep_pkg;

  localparam int IN_W  = 160;
  localparam int OUT_W = 96;

  localparam logic [31:0] RADIUS_RST = 32'd655360;
  localparam logic [15:0] THETA_RST  = 16'd16384;
  localparam logic [16:0] PHI_RST    = 17'd32768;
  localparam logic [15:0] QUARTER    = 16'd16384;

  localparam logic [63:0] PI_Q29  = 64'd1686629713;
  localparam logic [63:0] ONE_Q29 = 64'd536870912;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_NO_IN,
    COND_OUT_FULL,
    COND_ALWAYS
  } cond_t;

  // sin/cos of theta/phi: selects ROM angle, capture slot and multiplier operand
  typedef enum logic [1:0] {
    TRIG_ST,
    TRIG_CT,
    TRIG_SP,
    TRIG_CP
  } trig_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_RAD,
    MUL_PROD
  } mul_op_t;

  typedef enum logic [1:0] {
    RND_NONE,
    RND_15,
    RND_30
  } rnd_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_X,
    ACC_Y,
    ACC_Z
  } acc_t;

  typedef struct packed {
    cond_t   cond;
    step_t   tgt;
    logic    in_rdy;
    logic    ld_rmag;
    trig_t   ang;
    logic    cap_en;
    trig_t   cap_sel;
    mul_op_t mul;
    trig_t   mul_b;
    rnd_t    rnd;
    acc_t    acc;
    logic    out_ld;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_full;
  } stat_t;

  localparam ctrl_t CTRL_NOP = '{
    cond:    COND_NEXT,
    tgt:     '0,
    in_rdy:  1'b0,
    ld_rmag: 1'b0,
    ang:     TRIG_ST,
    cap_en:  1'b0,
    cap_sel: TRIG_ST,
    mul:     MUL_NONE,
    mul_b:   TRIG_ST,
    rnd:     RND_NONE,
    acc:     ACC_NONE,
    out_ld:  1'b0
  };

  // clamp a 34-bit two's complement value to signed 32 bits
  function automatic logic [31:0] sat34(input logic [33:0] v);
    logic [31:0] res;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      res = v[31:0];
    end else if (v[33]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

  // Q0.15 sine of r in [0, 16384] by Taylor series; evaluated at elaboration only
  function automatic logic [14:0] quarter_sine(input logic [31:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    x  = ({32'd0, r} * PI_Q29) >> 15;
    x2 = (x * x) >> 29;
    t  = ONE_Q29 - x2 / 64'd72;
    t  = ONE_Q29 - ((x2 * t) >> 29) / 64'd42;
    t  = ONE_Q29 - ((x2 * t) >> 29) / 64'd20;
    t  = ONE_Q29 - ((x2 * t) >> 29) / 64'd6;
    s  = (x * t) >> 29;
    q  = (s + 64'd8192) >> 14;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[14:0];
  endfunction

endpackage

>>> rtl/ocep_sine_rom.sv
// Quarter-wave sine ROM with quadrant folding and registered read.
`timescale 1ns / 1ps

module ocep_sine_rom #(
  parameter int SINE_INDEX_BITS = 12
) (
  input  logic        clk,
  input  logic [15:0] angle,
  output logic [14:0] mag,
  output logic        neg
);

  localparam int QB    = SINE_INDEX_BITS - 2;
  localparam int SH    = 16 - SINE_INDEX_BITS;
  localparam int DEPTH = (1 << QB) + 1;
  localparam int AW    = QB + 1;

  logic [14:0]   rom_m [DEPTH];
  logic [QB-1:0] r_idx;
  logic [AW-1:0] idx;
  logic [14:0]   mag_r;
  logic          neg_r;

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    assign rom_m[k] = ocep_pkg::quarter_sine(32'(k) << SH);
  end

  assign r_idx = angle[13 -: QB];

  // odd quadrants read the table mirrored
  always_comb begin
    if (angle[14]) begin
      idx = AW'(DEPTH - 1) - {1'b0, r_idx};
    end else begin
      idx = {1'b0, r_idx};
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= rom_m[idx];
    neg_r <= angle[15];
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

>>> rtl/ocep_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps

module ocep_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  ocep_pkg::stat_t  stat,
  output ocep_pkg::ctrl_t  ctrl
);

  localparam ocep_pkg::step_t S_IDLE   = ocep_pkg::step_t'(0);
  localparam ocep_pkg::step_t S_RD_ST  = ocep_pkg::step_t'(1);
  localparam ocep_pkg::step_t S_RD_CT  = ocep_pkg::step_t'(2);
  localparam ocep_pkg::step_t S_RD_SP  = ocep_pkg::step_t'(3);
  localparam ocep_pkg::step_t S_MUL_Z  = ocep_pkg::step_t'(4);
  localparam ocep_pkg::step_t S_RND_Z  = ocep_pkg::step_t'(5);
  localparam ocep_pkg::step_t S_ACC_Z  = ocep_pkg::step_t'(6);
  localparam ocep_pkg::step_t S_RND_Y  = ocep_pkg::step_t'(7);
  localparam ocep_pkg::step_t S_ACC_Y  = ocep_pkg::step_t'(8);
  localparam ocep_pkg::step_t S_RND_X  = ocep_pkg::step_t'(9);
  localparam ocep_pkg::step_t S_ACC_X  = ocep_pkg::step_t'(10);
  localparam ocep_pkg::step_t S_OUT    = ocep_pkg::step_t'(11);

  ocep_pkg::step_t step_r;
  ocep_pkg::step_t step_nxt;
  ocep_pkg::ctrl_t cw;
  logic            take;

  // control store
  always_comb begin
    cw = ocep_pkg::CTRL_NOP;
    unique case (step_r)
      S_IDLE: begin
        cw.in_rdy = 1'b1;
        cw.cond   = ocep_pkg::COND_NO_IN;
        cw.tgt    = S_IDLE;
      end
      S_RD_ST: begin
        cw.ang     = ocep_pkg::TRIG_ST;
        cw.ld_rmag = 1'b1;
      end
      S_RD_CT: begin
        cw.ang     = ocep_pkg::TRIG_CT;
        cw.cap_en  = 1'b1;
        cw.cap_sel = ocep_pkg::TRIG_ST;
      end
      S_RD_SP: begin
        cw.ang     = ocep_pkg::TRIG_SP;
        cw.cap_en  = 1'b1;
        cw.cap_sel = ocep_pkg::TRIG_CT;
      end
      S_MUL_Z: begin
        cw.ang     = ocep_pkg::TRIG_CP;
        cw.cap_en  = 1'b1;
        cw.cap_sel = ocep_pkg::TRIG_SP;
        cw.mul     = ocep_pkg::MUL_RAD;
        cw.mul_b   = ocep_pkg::TRIG_CT;
      end
      S_RND_Z: begin
        cw.cap_en  = 1'b1;
        cw.cap_sel = ocep_pkg::TRIG_CP;
        cw.rnd     = ocep_pkg::RND_15;
        cw.mul     = ocep_pkg::MUL_RAD;
        cw.mul_b   = ocep_pkg::TRIG_SP;
      end
      S_ACC_Z: begin
        cw.acc   = ocep_pkg::ACC_Z;
        cw.mul   = ocep_pkg::MUL_PROD;
        cw.mul_b = ocep_pkg::TRIG_ST;
      end
      S_RND_Y: begin
        cw.rnd   = ocep_pkg::RND_30;
        cw.mul   = ocep_pkg::MUL_RAD;
        cw.mul_b = ocep_pkg::TRIG_CP;
      end
      S_ACC_Y: begin
        cw.acc   = ocep_pkg::ACC_Y;
        cw.mul   = ocep_pkg::MUL_PROD;
        cw.mul_b = ocep_pkg::TRIG_ST;
      end
      S_RND_X: begin
        cw.rnd = ocep_pkg::RND_30;
      end
      S_ACC_X: begin
        cw.acc  = ocep_pkg::ACC_X;
        cw.cond = ocep_pkg::COND_OUT_FULL;
        cw.tgt  = S_ACC_X;
      end
      S_OUT: begin
        cw.out_ld = 1'b1;
        cw.cond   = ocep_pkg::COND_ALWAYS;
        cw.tgt    = S_IDLE;
      end
      default: begin
        cw.cond = ocep_pkg::COND_ALWAYS;
        cw.tgt  = S_IDLE;
      end
    endcase
  end

  always_comb begin
    unique case (cw.cond)
      ocep_pkg::COND_NEXT:     take = 1'b0;
      ocep_pkg::COND_NO_IN:    take = ~stat.in_valid;
      ocep_pkg::COND_OUT_FULL: take = stat.out_full;
      ocep_pkg::COND_ALWAYS:   take = 1'b1;
      default:                 take = 1'b1;
    endcase
    step_nxt = take ? cw.tgt : step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl = cw;

endmodule

>>> rtl/ocep_dp.sv
// Datapath: camera state, shared multiplier, rounding, accumulate and output register.
`timescale 1ns / 1ps

module ocep_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ocep_pkg::ctrl_t            ctrl,
  output ocep_pkg::stat_t            stat,
  input  logic                       in_tvalid,
  input  logic [ocep_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ocep_pkg::OUT_W-1:0] out_tdata,
  output logic [15:0]                rom_angle,
  input  logic [14:0]                rom_mag,
  input  logic                       rom_neg
);

  logic        in_fire;
  logic [31:0] d_pos [3];
  logic [31:0] d_rad;
  logic [15:0] d_theta;
  logic [15:0] d_phi;

  logic [31:0] tgt_r [3];
  logic [31:0] tgt_nxt [3];
  logic [31:0] rad_r;
  logic [31:0] rad_nxt;
  logic [15:0] theta_r;
  logic [15:0] theta_nxt;
  logic [16:0] phi_r;
  logic [16:0] phi_nxt;

  logic signed [17:0] th_sum;
  logic signed [17:0] th_wrap;
  logic signed [18:0] ph_sum;
  logic signed [18:0] ph_wrap;

  logic [31:0] rmag_r;
  logic        rneg_r;
  logic [14:0] trig_mag_r [4];
  logic        trig_neg_r [4];

  logic [46:0] mul_a;
  logic [14:0] mul_bv;
  logic [61:0] prod_r;
  logic        pneg_r;
  logic [61:0] rsum;
  logic [31:0] off_r;
  logic        off_neg_r;

  logic [31:0] acc_t_sel;
  logic [33:0] acc_sum;
  logic [31:0] eye_r [3];
  logic [1:0]  acc_idx;

  logic                       out_tvalid_r;
  logic [ocep_pkg::OUT_W-1:0] out_data_r;

  assign d_pos[0] = in_tdata[31:0];
  assign d_pos[1] = in_tdata[63:32];
  assign d_pos[2] = in_tdata[95:64];
  assign d_rad    = in_tdata[127:96];
  assign d_theta  = in_tdata[143:128];
  assign d_phi    = in_tdata[159:144];

  assign in_fire = ctrl.in_rdy & in_tvalid;

  // state update, one wrap step suffices for the delta range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tgt_nxt[i] = ocep_pkg::sat34({{2{tgt_r[i][31]}}, tgt_r[i]} +
                                   {{2{d_pos[i][31]}}, d_pos[i]});
    end
    rad_nxt = ocep_pkg::sat34({{2{rad_r[31]}}, rad_r} + {{2{d_rad[31]}}, d_rad});

    th_sum = $signed({2'b00, theta_r}) + $signed({{2{d_theta[15]}}, d_theta});
    if (th_sum < 0) begin
      th_wrap = th_sum + 18'sd32768;
    end else if (th_sum > 18'sd32768) begin
      th_wrap = th_sum - 18'sd32768;
    end else begin
      th_wrap = th_sum;
    end
    theta_nxt = th_wrap[15:0];

    ph_sum = $signed({2'b00, phi_r}) + $signed({{3{d_phi[15]}}, d_phi});
    if (ph_sum < 0) begin
      ph_wrap = ph_sum + 19'sd65536;
    end else if (ph_sum > 19'sd65536) begin
      ph_wrap = ph_sum - 19'sd65536;
    end else begin
      ph_wrap = ph_sum;
    end
    phi_nxt = ph_wrap[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        tgt_r[i] <= '0;
      end
      rad_r   <= ocep_pkg::RADIUS_RST;
      theta_r <= ocep_pkg::THETA_RST;
      phi_r   <= ocep_pkg::PHI_RST;
    end else if (in_fire) begin
      tgt_r   <= tgt_nxt;
      rad_r   <= rad_nxt;
      theta_r <= theta_nxt;
      phi_r   <= phi_nxt;
    end
  end

  always_comb begin
    unique case (ctrl.ang)
      ocep_pkg::TRIG_ST: rom_angle = theta_r;
      ocep_pkg::TRIG_CT: rom_angle = theta_r + ocep_pkg::QUARTER;
      ocep_pkg::TRIG_SP: rom_angle = phi_r[15:0];
      ocep_pkg::TRIG_CP: rom_angle = phi_r[15:0] + ocep_pkg::QUARTER;
      default:           rom_angle = theta_r;
    endcase
  end

  // multiplier operands: magnitudes only, sign tracked beside the product
  assign mul_a  = (ctrl.mul == ocep_pkg::MUL_RAD) ? {15'd0, rmag_r} : prod_r[46:0];
  assign mul_bv = trig_mag_r[ctrl.mul_b];

  // half-up on the magnitude gives half away from zero
  always_comb begin
    if (ctrl.rnd == ocep_pkg::RND_30) begin
      rsum = prod_r + (62'd1 << 29);
    end else begin
      rsum = prod_r + (62'd1 << 14);
    end
  end

  always_comb begin
    unique case (ctrl.acc)
      ocep_pkg::ACC_X: acc_idx = 2'd0;
      ocep_pkg::ACC_Y: acc_idx = 2'd1;
      ocep_pkg::ACC_Z: acc_idx = 2'd2;
      default:         acc_idx = 2'd0;
    endcase
    acc_t_sel = tgt_r[acc_idx];
    if (off_neg_r) begin
      acc_sum = {{2{acc_t_sel[31]}}, acc_t_sel} - {2'b00, off_r};
    end else begin
      acc_sum = {{2{acc_t_sel[31]}}, acc_t_sel} + {2'b00, off_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_rmag) begin
      rmag_r <= rad_r[31] ? (32'd0 - rad_r) : rad_r;
      rneg_r <= rad_r[31];
    end
    if (ctrl.cap_en) begin
      trig_mag_r[ctrl.cap_sel] <= rom_mag;
      trig_neg_r[ctrl.cap_sel] <= rom_neg;
    end
    if (ctrl.mul != ocep_pkg::MUL_NONE) begin
      prod_r <= 62'(mul_a) * 62'(mul_bv);
      pneg_r <= ((ctrl.mul == ocep_pkg::MUL_RAD) ? rneg_r : pneg_r) ^
                trig_neg_r[ctrl.mul_b];
    end
    if (ctrl.rnd != ocep_pkg::RND_NONE) begin
      off_r     <= (ctrl.rnd == ocep_pkg::RND_30) ? rsum[61:30] : rsum[46:15];
      off_neg_r <= pneg_r;
    end
    if (ctrl.acc != ocep_pkg::ACC_NONE) begin
      eye_r[acc_idx] <= ocep_pkg::sat34(acc_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld) begin
      out_data_r <= {eye_r[2], eye_r[1], eye_r[0]};
    end
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_tdata     = out_data_r;
  assign stat.in_valid = in_tvalid;
  assign stat.out_full = out_tvalid_r & ~out_tready;

endmodule

>>> rtl/orbit_camera_eye_position.sv
// Top level of the orbit camera eye position block.
`timescale 1ns / 1ps
// A new request is taken only once the previous result is loaded; the sequencer
// program walks one sine ROM port and one 47x15 multiplier through five products
// in order.
// A result not yet taken holds the program before its last step.
// Reset: synchronous; target 0, radius ten, theta PI/2, phi PI, no clearing pass.

module orbit_camera_eye_position #(
  parameter int SINE_INDEX_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // delta_x, delta_y, delta_z, delta_radius, delta_theta, delta_phi
  input  logic [ocep_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // eye_x, eye_y, eye_z
  output logic [ocep_pkg::OUT_W-1:0] out_tdata
);

  ocep_pkg::ctrl_t ctrl;
  ocep_pkg::stat_t stat;
  logic [15:0]     rom_angle;
  logic [14:0]     rom_mag;
  logic            rom_neg;

  ocep_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  ocep_sine_rom #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_rom (
    .clk   (clk),
    .angle (rom_angle),
    .mag   (rom_mag),
    .neg   (rom_neg)
  );

  ocep_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .rom_angle  (rom_angle),
    .rom_mag    (rom_mag),
    .rom_neg    (rom_neg)
  );

  assign in_tready = ctrl.in_rdy;

endmodule

>>> rtl/ocep_chk.sv
// Port-level checker for the orbit camera eye block, bound to the top level.
`timescale 1ns / 1ps

module ocep_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [ocep_pkg::OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while one is in flight");

  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("not ready for a request after presenting a result");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind orbit_camera_eye_position ocep_chk u_chk (.*);
